### rtl/rts_pkg.sv
package rts_pkg;
  localparam int NUM_FRAMES = 6;
  localparam int FRAC_BITS  = 16;
  localparam int WORDS_PER_FRAME = 12;
  localparam int MEM_DEPTH = NUM_FRAMES * WORDS_PER_FRAME;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int FID_W = 3;

  localparam logic [2:0] KIND_WRITE   = 3'd0;
  localparam logic [2:0] KIND_READ    = 3'd1;
  localparam logic [2:0] KIND_INVERT  = 3'd2;
  localparam logic [2:0] KIND_COMPOSE = 3'd3;
  localparam logic [2:0] KIND_ADVANCE = 3'd4;
  localparam logic [2:0] KIND_STATUS  = 3'd5;

  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_FRAME   = 3'd1;
  localparam logic [2:0] ERR_ROW     = 3'd2;
  localparam logic [2:0] ERR_OVERLAP = 3'd4;

  localparam logic [1:0] ST_SAME   = 2'd0;
  localparam logic [1:0] ST_NEVER  = 2'd1;
  localparam logic [1:0] ST_OLDER  = 2'd2;
  localparam logic [1:0] ST_NEWER  = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic [FID_W-1:0]   frame_a;
    logic [FID_W-1:0]   frame_b;
    logic [FID_W-1:0]   frame_dst;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
  } rts_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         tick_status;
    logic [2:0]         error;
  } rts_out_t;

  // word address of (frame, row, col)
  function automatic logic [ADDR_W-1:0] waddr(logic [FID_W-1:0] f, logic [1:0] r,
                                              logic [1:0] c);
    logic [ADDR_W+3:0] a;
    a = (ADDR_W+4)'(f) * (ADDR_W+4)'(WORDS_PER_FRAME) + (ADDR_W+4)'({r, 2'b00})
        + (ADDR_W+4)'(c);
    return a[ADDR_W-1:0];
  endfunction

  // identity word value for a word index inside a frame
  function automatic logic signed [31:0] ident_word(logic [3:0] w);
    logic signed [31:0] v;
    v = '0;
    if (w == 4'd0 || w == 4'd5 || w == 4'd10) v = 32'sd1 <<< FRAC_BITS;
    return v;
  endfunction
endpackage

### rtl/rts_if.sv
interface rts_in_if;
  import rts_pkg::*;
  logic    valid;
  logic    ready;
  rts_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rts_out_if;
  import rts_pkg::*;
  logic     valid;
  logic     ready;
  rts_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/rts_mem.sv
module rts_mem
  import rts_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [31:0]       wdata,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [31:0]       rdata
);
  logic [31:0] mem [MEM_DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr_i] <= wdata;
    rdata <= mem[raddr_i];
  end
endmodule

### rtl/rts_mac.sv
module rts_mac
  import rts_pkg::*;
(
  input  logic               clk,
  input  logic               clr,
  input  logic               mul_en,
  input  logic               neg,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic               acc_en,
  input  logic signed [31:0] addend,
  output logic signed [31:0] result
);
  logic signed [63:0] prod_r;
  logic signed [66:0] acc_r;
  logic signed [66:0] rnd;
  logic signed [50:0] sh;
  logic signed [51:0] tot;

  // multiply, then accumulate exactly
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= neg ? -(a * b) : a * b;
    if (clr) acc_r <= '0;
    else if (acc_en) acc_r <= acc_r + 67'(prod_r);
  end

  // round half up, add translation, saturate
  always_comb begin
    rnd = acc_r + (67'sd1 <<< (FRAC_BITS - 1));
    sh  = 51'(rnd >>> FRAC_BITS);
    tot = 52'(sh) + 52'(addend);
    if (tot > 52'sd2147483647) result = 32'h7fffffff;
    else if (tot < -52'sd2147483648) result = 32'h80000000;
    else result = tot[31:0];
  end
endmodule

### rtl/rigid_transform_store_core.sv
// Transform store: six 3x4 Q16.16 transforms in one 72-word RAM with one write port
// and one registered read port, plus per-frame tick stamps. After reset the core
// writes identity into every RAM word (S_INIT) and accepts no word until it is done.
// Words are taken one at a time, and the next word is taken only after the result
// word has left. Each accepted word passes through S_RD; an item with an error then
// goes straight to S_OUT, while write, read, tick advance, status and the unused
// kinds pass through S_RDW first. Invert copies 9 rotation words, each through S_CPA
// and S_CPW, and builds 3 translation words. Compose builds 12 words. Each built
// word takes three products, each through the one RAM read port and the shared
// multiply-accumulate (two reads, multiply, accumulate in S_FA, S_FB, S_MUL and S_ACC),
// then S_TA fetches the translation term and S_WR writes the word back.
module rigid_transform_store_core
  import rts_pkg::*;
(
  input logic clk,
  input logic rst_n,
  rts_in_if.sink    in_ch,
  rts_out_if.source out_ch
);
  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_RDW = 4'd3,
                         S_OUT = 4'd4, S_FA = 4'd5, S_FB = 4'd6, S_MUL = 4'd7,
                         S_ACC = 4'd8, S_TA = 4'd9, S_WR = 4'd10, S_CPA = 4'd11,
                         S_CPW = 4'd12;

  logic [3:0]  state_r, state_nxt;
  rts_in_t     it_r;
  rts_out_t    res_r;
  logic        ovalid_r;
  logic [31:0] stamp_r [NUM_FRAMES];
  logic [31:0] tick_r;
  logic [ADDR_W-1:0] icnt_r;
  logic [3:0]  wcnt_r;
  logic [1:0]  i_r, j_r, k_r;
  logic        inv_r;
  logic signed [31:0] opa_r, tadd_r;

  logic              we;
  logic [ADDR_W-1:0] wa, ra;
  logic [31:0]       wd, rdata;
  logic              mclr, mmul, macc;
  logic signed [31:0] mres;
  logic [2:0]        err;
  logic [1:0]        tstat;

  rts_mem u_mem (.clk(clk), .we(we), .waddr_i(wa), .wdata(wd), .raddr_i(ra),
                 .rdata(rdata));
  rts_mac u_mac (.clk(clk), .clr(mclr), .mul_en(mmul), .neg(inv_r), .a(opa_r),
                 .b(rdata), .acc_en(macc), .addend(tadd_r), .result(mres));

  assign in_ch.ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  // error check on the held item
  always_comb begin
    err = ERR_OK;
    unique case (it_r.kind) inside
      KIND_WRITE, KIND_READ: begin
        if (32'(it_r.frame_a) >= NUM_FRAMES) err = ERR_FRAME;
        else if (it_r.row == 2'd3) err = ERR_ROW;
      end
      KIND_INVERT: begin
        if (32'(it_r.frame_a) >= NUM_FRAMES || 32'(it_r.frame_dst) >= NUM_FRAMES)
          err = ERR_FRAME;
        else if (it_r.frame_a == it_r.frame_dst) err = ERR_OVERLAP;
      end
      KIND_COMPOSE: begin
        if (32'(it_r.frame_a) >= NUM_FRAMES || 32'(it_r.frame_b) >= NUM_FRAMES ||
            32'(it_r.frame_dst) >= NUM_FRAMES) err = ERR_FRAME;
        else if (it_r.frame_dst == it_r.frame_a || it_r.frame_dst == it_r.frame_b)
          err = ERR_OVERLAP;
      end
      KIND_STATUS: if (32'(it_r.frame_a) >= NUM_FRAMES) err = ERR_FRAME;
      default: err = ERR_OK;
    endcase
  end

  // tick status of the held frame against frame 0
  always_comb begin
    tstat = ST_SAME;
    if (32'(it_r.frame_a) < NUM_FRAMES) begin
      if (it_r.frame_a != '0 && stamp_r[it_r.frame_a] == stamp_r[0]) tstat = ST_SAME;
      else if (stamp_r[0] == '0) tstat = ST_NEVER;
      else if (stamp_r[0] < stamp_r[it_r.frame_a]) tstat = ST_OLDER;
      else tstat = ST_NEWER;
    end
  end

  // RAM address and MAC control
  always_comb begin
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    mclr = 1'b0; mmul = 1'b0; macc = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        we = 1'b1; wa = icnt_r;
        wd = ident_word(wcnt_r);
        if (32'(icnt_r) == MEM_DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = S_RD;
      S_RD: begin
        ra = waddr(it_r.frame_a, it_r.row, it_r.col);
        if (err != ERR_OK) state_nxt = S_OUT;
        else if (it_r.kind == KIND_INVERT) begin
          mclr = 1'b1; state_nxt = S_CPA;
        end else if (it_r.kind == KIND_COMPOSE) begin
          mclr = 1'b1; state_nxt = S_FA;
        end else state_nxt = S_RDW;
      end
      S_RDW: begin
        if (it_r.kind == KIND_WRITE) begin
          we = 1'b1; wa = waddr(it_r.frame_a, it_r.row, it_r.col); wd = it_r.value;
        end
        state_nxt = S_OUT;
      end
      S_CPA: ra = waddr(it_r.frame_a, k_r, i_r);
      S_CPW: begin
        we = 1'b1; wa = waddr(it_r.frame_dst, i_r, k_r); wd = rdata;
        ra = waddr(it_r.frame_a, k_r, i_r);
      end
      S_FA: begin
        // left operand: compose R1[i][k]; invert R[k][i]
        ra = inv_r ? waddr(it_r.frame_a, k_r, i_r) : waddr(it_r.frame_a, i_r, k_r);
      end
      S_FB: begin
        ra = inv_r ? waddr(it_r.frame_a, k_r, 2'd3) : waddr(it_r.frame_b, k_r, j_r);
      end
      S_MUL: begin
        mmul = 1'b1;
        ra = waddr(it_r.frame_a, i_r, 2'd3);
      end
      S_ACC: begin
        macc = 1'b1;
        ra = waddr(it_r.frame_a, i_r, 2'd3);
      end
      S_TA: ra = waddr(it_r.frame_a, i_r, 2'd3);
      S_WR: begin
        we = 1'b1; wa = waddr(it_r.frame_dst, i_r, j_r); wd = mres; mclr = 1'b1;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; icnt_r <= '0; wcnt_r <= '0; ovalid_r <= 1'b0; tick_r <= '0;
      for (int f = 0; f < NUM_FRAMES; f++) stamp_r[f] <= '0;
      i_r <= '0; j_r <= '0; k_r <= '0; inv_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_INIT: begin
          icnt_r <= icnt_r + 1'b1;
          wcnt_r <= (wcnt_r == 4'(WORDS_PER_FRAME - 1)) ? '0 : wcnt_r + 1'b1;
          state_r <= state_nxt;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            it_r <= in_ch.data;
            inv_r <= (in_ch.data.kind == KIND_INVERT);
            i_r <= '0; j_r <= '0; k_r <= '0;
          end
          state_r <= state_nxt;
        end
        S_RD: begin
          res_r <= '{read_value: '0,
                     tick_status: (err == ERR_OK && it_r.kind == KIND_STATUS) ?
                                  tstat : ST_SAME,
                     error: err};
          if (err == ERR_OK && it_r.kind == KIND_ADVANCE) begin
            if (tick_r == 32'hffffffff) begin
              tick_r <= 32'd1;
              for (int f = 0; f < NUM_FRAMES; f++) stamp_r[f] <= '0;
            end else tick_r <= tick_r + 1'b1;
          end
          state_r <= state_nxt;
        end
        S_RDW: begin
          if (it_r.kind == KIND_READ) res_r.read_value <= rdata;
          if (it_r.kind == KIND_WRITE) stamp_r[it_r.frame_a] <= tick_r;
          state_r <= state_nxt;
        end
        S_CPA: state_r <= S_CPW;
        S_CPW: begin
          // copy transposed rotation, then translation terms
          if (k_r == 2'd2) begin
            k_r <= '0;
            if (i_r == 2'd2) begin
              i_r <= '0; j_r <= 2'd3; state_r <= S_FA;
            end else begin
              i_r <= i_r + 1'b1; state_r <= S_CPA;
            end
          end else begin
            k_r <= k_r + 1'b1; state_r <= S_CPA;
          end
        end
        S_FA: state_r <= S_FB;
        S_FB: begin
          opa_r <= rdata; state_r <= S_MUL;
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          if (k_r == 2'd2) begin
            k_r <= '0; state_r <= S_TA;
          end else begin
            k_r <= k_r + 1'b1; state_r <= S_FA;
          end
        end
        S_TA: begin
          tadd_r <= (j_r == 2'd3 && !inv_r) ? rdata : '0;
          state_r <= S_WR;
        end
        S_WR: begin
          if (inv_r) begin
            if (i_r == 2'd2) begin
              stamp_r[it_r.frame_dst] <= tick_r; state_r <= S_OUT;
            end else begin
              i_r <= i_r + 1'b1; state_r <= S_FA;
            end
          end else if (j_r == 2'd3) begin
            j_r <= '0;
            if (i_r == 2'd2) begin
              stamp_r[it_r.frame_dst] <= tick_r; state_r <= S_OUT;
            end else begin
              i_r <= i_r + 1'b1; state_r <= S_FA;
            end
          end else begin
            j_r <= j_r + 1'b1; state_r <= S_FA;
          end
        end
        S_OUT: begin
          ovalid_r <= 1'b1; state_r <= state_nxt;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/rts_tb_if.sv
`timescale 1ns / 1ps
// Channel interfaces come from the RTL (rts_in_if, rts_out_if); this file holds
// the scoreboard class shared by the test top.
package rts_tb_pkg;
  import rts_pkg::*;

  class transform_scoreboard;
    logic signed [31:0] words [NUM_FRAMES*WORDS_PER_FRAME];
    logic [31:0]        stamps [NUM_FRAMES];
    logic [31:0]        tick;
    rts_out_t           pending [$];
    int                 failures;

    function new();
      reset_state();
    endfunction

    function void reset_state();
      for (int f = 0; f < NUM_FRAMES; f++) begin
        for (int w = 0; w < WORDS_PER_FRAME; w++)
          words[f*WORDS_PER_FRAME+w] = (w == 0 || w == 5 || w == 10) ?
                                       (32'sd1 <<< FRAC_BITS) : 32'sd0;
        stamps[f] = '0;
      end
      tick = '0;
      failures = 0;
    endfunction

    function logic signed [31:0] wd(int f, int r, int c);
      return words[f*WORDS_PER_FRAME + r*4 + c];
    endfunction

    // round once, add offset, saturate to 32 bits
    function logic signed [31:0] round_sat(logic signed [127:0] sum,
                                           logic signed [127:0] addend);
      logic signed [127:0] v;
      v = ((sum + (128'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS) + addend;
      if (v > 128'sd2147483647) v = 128'sd2147483647;
      if (v < -128'sd2147483648) v = -128'sd2147483648;
      return v[31:0];
    endfunction

    // predict the result of one accepted word and update the shadow state
    function void note_input(rts_in_t it);
      rts_out_t r;
      logic signed [31:0] nw [WORDS_PER_FRAME];
      logic signed [127:0] s;
      int fa, fb, fd;
      fa = it.frame_a; fb = it.frame_b; fd = it.frame_dst;
      r = '0;
      case (it.kind)
        KIND_WRITE, KIND_READ: begin
          if (fa >= NUM_FRAMES) r.error = ERR_FRAME;
          else if (it.row > 2) r.error = ERR_ROW;
          else if (it.kind == KIND_WRITE) begin
            words[fa*WORDS_PER_FRAME + it.row*4 + it.col] = it.value;
            stamps[fa] = tick;
          end else r.read_value = wd(fa, it.row, it.col);
        end
        KIND_INVERT: begin
          if (fa >= NUM_FRAMES || fd >= NUM_FRAMES) r.error = ERR_FRAME;
          else if (fa == fd) r.error = ERR_OVERLAP;
          else begin
            for (int i = 0; i < 3; i++) begin
              s = '0;
              for (int k = 0; k < 3; k++) begin
                nw[i*4+k] = wd(fa, k, i);
                s = s - 128'(wd(fa, k, i)) * 128'(wd(fa, k, 3));
              end
              nw[i*4+3] = round_sat(s, 128'sd0);
            end
            for (int w = 0; w < WORDS_PER_FRAME; w++) words[fd*WORDS_PER_FRAME+w] = nw[w];
            stamps[fd] = tick;
          end
        end
        KIND_COMPOSE: begin
          if (fa >= NUM_FRAMES || fb >= NUM_FRAMES || fd >= NUM_FRAMES) r.error = ERR_FRAME;
          else if (fd == fa || fd == fb) r.error = ERR_OVERLAP;
          else begin
            for (int i = 0; i < 3; i++)
              for (int j = 0; j < 4; j++) begin
                s = '0;
                for (int k = 0; k < 3; k++)
                  s = s + 128'(wd(fa, i, k)) * 128'(wd(fb, k, j));
                nw[i*4+j] = round_sat(s, j == 3 ? 128'(wd(fa, i, 3)) : 128'sd0);
              end
            for (int w = 0; w < WORDS_PER_FRAME; w++) words[fd*WORDS_PER_FRAME+w] = nw[w];
            stamps[fd] = tick;
          end
        end
        KIND_ADVANCE: begin
          if (tick == 32'hFFFF_FFFF) begin
            tick = 32'd1;
            for (int f = 0; f < NUM_FRAMES; f++) stamps[f] = '0;
          end else tick = tick + 32'd1;
        end
        KIND_STATUS: begin
          if (fa >= NUM_FRAMES) r.error = ERR_FRAME;
          else if (fa > 0 && stamps[fa] == stamps[0]) r.tick_status = ST_SAME;
          else if (stamps[0] == 0) r.tick_status = ST_NEVER;
          else if (stamps[0] < stamps[fa]) r.tick_status = ST_OLDER;
          else r.tick_status = ST_NEWER;
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(rts_out_t got);
      rts_out_t exp_r;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        failures++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.read_value !== exp_r.read_value) begin
        $error("read_value expected %0d actual %0d", exp_r.read_value, got.read_value);
        failures++;
      end
      if (got.tick_status !== exp_r.tick_status) begin
        $error("tick_status expected %0d actual %0d", exp_r.tick_status, got.tick_status);
        failures++;
      end
      if (got.error !== exp_r.error) begin
        $error("error expected %0d actual %0d", exp_r.error, got.error);
        failures++;
      end
    endfunction
  endclass
endpackage

### tb/rigid_transform_store_core_test.sv
`timescale 1ns / 1ps
module rigid_transform_store_core_test;
  import rts_pkg::*;
  import rts_tb_pkg::*;

  localparam int IN_W = $bits(rts_in_t);
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  rts_in_if  in_ch();
  rts_out_if out_ch();
  transform_scoreboard board = new();
  bit long_stall = 1'b0;

  rigid_transform_store_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // note accepted words and check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) board.note_input(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int phase;
    out_ch.ready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (long_stall) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_stall = 1'b0;
      end
      phase++;
      if ((phase / 300) % 3 == 2) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 131072)) - 32'sd65536;
      3: return $signed($urandom_range(0, 8388608)) - 32'sd4194304;
      default: return $signed($urandom());
    endcase
  endfunction

  // offer one word and hold it until accepted
  task automatic send(rts_in_t it);
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_sender();
    in_ch.valid <= 1'b0;
    in_ch.data  <= IN_W'({$urandom(), $urandom()});
  endtask

  function automatic rts_in_t make(logic [2:0] k, int a, int b, int d, int r, int c,
                                   logic signed [31:0] v);
    rts_in_t it;
    it = IN_W'({$urandom(), $urandom()});
    it.kind = k; it.frame_a = 3'(a); it.frame_b = 3'(b); it.frame_dst = 3'(d);
    it.row = 2'(r); it.col = 2'(c); it.value = v;
    return it;
  endfunction

  function automatic rts_in_t rand_item();
    rts_in_t it;
    int p;
    it = IN_W'({$urandom(), $urandom()});
    p = $urandom_range(0, 99);
    // mostly valid frames and rows; some noise
    if (p < 92) begin
      it.frame_a = 3'($urandom_range(0, NUM_FRAMES-1));
      it.frame_b = 3'($urandom_range(0, NUM_FRAMES-1));
      it.frame_dst = 3'($urandom_range(0, NUM_FRAMES-1));
      it.row = 2'($urandom_range(0, 2));
    end
    p = $urandom_range(0, 99);
    if (p < 30) it.kind = KIND_WRITE;
    else if (p < 50) it.kind = KIND_READ;
    else if (p < 60) it.kind = KIND_INVERT;
    else if (p < 70) it.kind = KIND_COMPOSE;
    else if (p < 80) it.kind = KIND_ADVANCE;
    else if (p < 97) it.kind = KIND_STATUS;
    else it.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO;
    it.value = rand_value();
    return it;
  endfunction

  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: errors, extremes, every kind, frame 0 status
    send(make(KIND_STATUS, 0, 0, 0, 0, 0, 0));
    send(make(KIND_STATUS, 3, 0, 0, 0, 0, 0));
    send(make(KIND_READ, 0, 0, 0, 0, 0, 0));
    send(make(KIND_READ, 7, 0, 0, 0, 0, 0));
    send(make(KIND_WRITE, 6, 0, 0, 1, 1, 5));
    send(make(KIND_WRITE, 1, 0, 0, 3, 2, 5));
    send(make(KIND_READ, 2, 0, 0, 3, 3, 0));
    send(make(KIND_ADVANCE, 0, 0, 0, 0, 0, 0));
    send(make(KIND_WRITE, 1, 0, 0, 0, 3, 32'sh7FFF_FFFF));
    send(make(KIND_WRITE, 1, 0, 0, 2, 2, 32'sh8000_0000));
    send(make(KIND_WRITE, 1, 0, 0, 1, 0, 32'sh7FFF_FFFF));
    send(make(KIND_READ, 1, 0, 0, 2, 2, 0));
    send(make(KIND_INVERT, 1, 0, 2, 0, 0, 0));
    send(make(KIND_INVERT, 2, 0, 2, 0, 0, 0));
    send(make(KIND_INVERT, 1, 0, 7, 0, 0, 0));
    send(make(KIND_COMPOSE, 1, 1, 3, 0, 0, 0));
    send(make(KIND_COMPOSE, 1, 2, 2, 0, 0, 0));
    send(make(KIND_COMPOSE, 4, 6, 3, 0, 0, 0));
    send(make(KIND_READ, 3, 0, 0, 0, 3, 0));
    send(make(KIND_STATUS, 3, 0, 0, 0, 0, 0));
    send(make(KIND_WRITE, 0, 0, 0, 0, 0, 32'sh0001_0000));
    send(make(KIND_STATUS, 0, 0, 0, 0, 0, 0));
    send(make(KIND_STATUS, 3, 0, 0, 0, 0, 0));
    send(make(KIND_SPARE_LO, 1, 1, 1, 1, 1, 1));
    send(make(KIND_SPARE_HI, 7, 7, 7, 3, 3, -1));

    // the tick wrap needs 2^32 advances and lies beyond a run of this length
    idle_sender();
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    long_stall = 1'b1;
    for (int n = 0; n < 40; n++) send(rand_item());

    // random bursts with gaps
    for (int n = 0; n < 360; ) begin
      int burst;
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++) send(rand_item());
      if ($urandom_range(0, 2) != 0) begin
        idle_sender();
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
      if (n > 180 && n < 195) begin
        idle_sender();
        wait_drained();
      end
    end
    idle_sender();
    wait_drained();
    repeat (200) @(negedge clk);
    if (board.failures == 0 && board.pending.size() == 0)
      $display("rigid_transform_store_core_test OK");
    else
      $display("rigid_transform_store_core_test NOT OK");
    $finish;
  end

  initial begin
    #(20ns * 600000);
    $display("rigid_transform_store_core_test NOT OK");
    $finish;
  end
endmodule
